FILE: rtl/dhoat_pkg.sv
// shared types, widths and constants of the double-hash open-address table
// no dependencies
package dhoat_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int KEY_W = 32;
	localparam int VALUE_W = 32;
	localparam int HASH_W = 64;
	localparam int OP_W = 2;
	localparam int STATUS_W = 2;
	localparam int LIVE_W = 11;
	localparam int SLOT_W = 2;

	localparam logic [HASH_W-1:0] MIX_GOLD = 64'h9e3779b97f4a7c15;
	localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
	localparam logic [HASH_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

	localparam logic [OP_W-1:0] OP_GET = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_USED = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_TOMB = 2'd2;

	function automatic logic [HASH_W-1:0] xor_shift(input logic [HASH_W-1:0] x,
			input int unsigned sh);
		return x ^ (x >> sh);
	endfunction

endpackage

FILE: rtl/dhoat_if.sv
// request and response channels of the table (valid/ready with payload)
// depends on dhoat_pkg
interface dhoat_req_if import dhoat_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic [KEY_W-1:0] key;
	logic [HASH_W-1:0] key_hash;
	logic [VALUE_W-1:0] value;

	modport source(output valid, operation, key, key_hash, value, input ready);
	modport sink(input valid, operation, key, key_hash, value, output ready);
endinterface

interface dhoat_rsp_if import dhoat_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0] result_value;
	logic [LIVE_W-1:0] live_count;

	modport source(output valid, status, result_value, live_count, input ready);
	modport sink(input valid, status, result_value, live_count, output ready);
endinterface

FILE: rtl/dhoat_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dhoat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/dhoat_hash.sv
// splitmix64 mixing of the raw hash into start slot and odd probe step
// shared 32x32 multiplier, 8-bit-per-cycle remainder unit; depends on dhoat_pkg
module dhoat_hash import dhoat_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY)
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [HASH_W-1:0] hash,
	output logic done,
	output logic [IDX_W-1:0] start_slot,
	output logic [IDX_W:0] step
);
	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_INIT = 2'd1;
	localparam logic [1:0] H_MUL = 2'd2;
	localparam logic [1:0] H_DIV = 2'd3;

	localparam int DIV_BITS = 8;
	localparam int DIV_CYC = HASH_W / DIV_BITS;
	localparam int DC_W = $clog2(DIV_CYC);
	localparam logic [IDX_W:0] D_START = (IDX_W+1)'(CAPACITY);
	localparam logic [IDX_W:0] D_STEP = (IDX_W+1)'(CAPACITY - 1);

	logic [1:0] hstate_q;
	logic second_q;
	logic mulb_q;
	logic [1:0] mph_q;
	logic [DC_W-1:0] div_cnt_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] x_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] prod_q;
	logic [HASH_W-1:0] num_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W:0] step_q;
	logic done_q;

	logic [HASH_W-1:0] mix_src;
	logic [HASH_W-1:0] mul_const;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [HASH_W-1:0] mul_p;
	logic [HASH_W-1:0] mul_fin;
	logic [IDX_W:0] div_d;
	logic [IDX_W-1:0] rem_r;
	logic [IDX_W:0] rem_t;
	logic [IDX_W-1:0] rem_next;
	logic [IDX_W:0] step_sum;

	assign mix_src = second_q ? (hash_q ^ MIX_GOLD) : hash_q;
	assign mul_const = mulb_q ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a = (mph_q == 2'd2) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (mph_q == 2'd1) ? mul_const[63:32] : mul_const[31:0];
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	// low 64 bits of the full product: cross terms only touch the upper half
	assign mul_fin = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
	assign div_d = second_q ? D_STEP : D_START;
	assign step_sum = {1'b0, rem_next} + (IDX_W+1)'(1);

	// restoring remainder, msb first
	always_comb begin
		rem_r = rem_q;
		rem_t = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_t = {rem_r, num_q[HASH_W-1-i]};
			if (rem_t >= div_d) begin
				rem_t = rem_t - div_d;
			end
			rem_r = rem_t[IDX_W-1:0];
		end
		rem_next = rem_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
			second_q <= 1'b0;
			mulb_q <= 1'b0;
			mph_q <= '0;
			div_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (hstate_q == H_DIV) && second_q
				&& (div_cnt_q == DC_W'(DIV_CYC - 1));
			unique case (hstate_q)
				H_IDLE: begin
					if (go) begin
						second_q <= 1'b0;
						hstate_q <= H_INIT;
					end
				end
				H_INIT: begin
					mulb_q <= 1'b0;
					mph_q <= '0;
					hstate_q <= H_MUL;
				end
				H_MUL: begin
					mph_q <= mph_q + 2'd1;
					if (mph_q == 2'd3) begin
						if (mulb_q) begin
							div_cnt_q <= '0;
							hstate_q <= H_DIV;
						end else begin
							mulb_q <= 1'b1;
						end
					end
				end
				H_DIV: begin
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_cnt_q == DC_W'(DIV_CYC - 1)) begin
						if (second_q) begin
							hstate_q <= H_IDLE;
						end else begin
							second_q <= 1'b1;
							hstate_q <= H_INIT;
						end
					end
				end
				default: hstate_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (hstate_q)
			H_IDLE: begin
				if (go) begin
					hash_q <= hash;
				end
			end
			H_INIT: begin
				x_q <= xor_shift(mix_src + MIX_GOLD, 30);
			end
			H_MUL: begin
				prod_q <= mul_p;
				if (mph_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (mph_q == 2'd2) begin
					acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				end else if (mph_q == 2'd3) begin
					if (mulb_q) begin
						num_q <= xor_shift(mul_fin, 31);
						rem_q <= '0;
					end else begin
						x_q <= xor_shift(mul_fin, 27);
					end
				end
			end
			H_DIV: begin
				num_q <= num_q << DIV_BITS;
				rem_q <= rem_next;
				if (div_cnt_q == DC_W'(DIV_CYC - 1)) begin
					if (second_q) begin
						step_q <= step_sum | (IDX_W+1)'(1);
					end else begin
						start_q <= rem_next;
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign start_slot = start_q;
	assign step = step_q;
endmodule

FILE: rtl/double_hash_open_address_table.sv
// top level of the double-hash open-address key/value table
// depends on dhoat_pkg, dhoat_if, dhoat_ram, dhoat_hash
//
// One request at a time. After reset the slot store is swept to empty, one
// slot per cycle, before the first request is taken. A get, insert or
// remove first mixes the hash into a start slot and a probe step, using the
// shared 32x32 multiplier, which builds each 64-bit product in parts, and
// the remainder unit (8 bits per cycle), then probes 1 to CAPACITY slots,
// one slot per cycle from the single slot memory, whose read is registered.
// An unused operation code skips the hash and the probe. The response sits
// in an output register, so the next request is taken while it waits.
module double_hash_open_address_table import dhoat_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	dhoat_req_if.sink req,
	dhoat_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int WIDE_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
	localparam int WORD_W = SLOT_W + KEY_W + VALUE_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_HASH = 3'd2;
	localparam logic [2:0] ST_RD = 3'd3;
	localparam logic [2:0] ST_CHK = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [IDX_W-1:0] clr_q;
	logic [OP_W-1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [VALUE_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W:0] step_q;
	logic tomb_seen_q;
	logic [IDX_W-1:0] tomb_q;
	logic [CNT_W-1:0] cnt_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [VALUE_W-1:0] res_val_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VALUE_W-1:0] out_val_q;
	logic [LIVE_W-1:0] out_live_q;

	logic accept;
	logic hash_done;
	logic [IDX_W-1:0] hash_start;
	logic [IDX_W:0] hash_step;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic [SLOT_W-1:0] rd_slot;
	logic [KEY_W-1:0] rd_key;
	logic [VALUE_W-1:0] rd_val;

	logic [IDX_W:0] idx_sum;
	logic [IDX_W-1:0] idx_next;
	logic is_empty;
	logic is_tomb;
	logic is_hit;
	logic finish;
	logic have_dst;
	logic [IDX_W-1:0] dst;
	logic [CNT_W-1:0] cnt_next;
	logic [STATUS_W-1:0] status_next;
	logic [VALUE_W-1:0] val_next;
	logic [WIDE_W-1:0] cnt_wide;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	dhoat_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.go(accept && (req.operation != OP_UNUSED)),
		.hash(req.key_hash),
		.done(hash_done),
		.start_slot(hash_start),
		.step(hash_step)
	);

	dhoat_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_slots (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_slot = rd_data[WORD_W-1 -: SLOT_W];
	assign rd_key = rd_data[VALUE_W +: KEY_W];
	assign rd_val = rd_data[VALUE_W-1:0];

	assign idx_sum = {1'b0, idx_q} + step_q;
	assign idx_next = (idx_sum >= (IDX_W+1)'(CAPACITY))
		? IDX_W'(idx_sum - (IDX_W+1)'(CAPACITY)) : idx_sum[IDX_W-1:0];
	assign is_empty = (rd_slot == SLOT_EMPTY);
	assign is_tomb = (rd_slot == SLOT_TOMB);
	assign is_hit = (rd_slot == SLOT_USED) && (rd_key == key_q);
	assign finish = is_empty || is_hit || (idx_next == start_q);
	assign rd_addr = (state_q == ST_CHK) ? idx_next : idx_q;

	// insert target: earliest tombstone on the path, else the empty slot
	always_comb begin
		have_dst = 1'b1;
		dst = idx_q;
		if (tomb_seen_q) begin
			dst = tomb_q;
		end else if (!is_tomb && !is_empty) begin
			have_dst = 1'b0;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = {rd_slot, rd_key, rd_val};
		cnt_next = cnt_q;
		status_next = STATUS_NOT_FOUND;
		val_next = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = {SLOT_EMPTY, {(KEY_W + VALUE_W){1'b0}}};
		end else if (state_q == ST_CHK && finish) begin
			case (op_q)
				OP_GET: begin
					if (is_hit) begin
						status_next = STATUS_OK;
						val_next = rd_val;
					end
				end
				OP_REMOVE: begin
					if (is_hit) begin
						status_next = STATUS_OK;
						val_next = rd_val;
						wr_en = 1'b1;
						wr_data = {SLOT_TOMB, rd_key, rd_val};
						cnt_next = cnt_q - CNT_W'(1);
					end
				end
				OP_INSERT: begin
					if (is_hit) begin
						status_next = STATUS_OK;
						wr_en = 1'b1;
						wr_data = {SLOT_USED, key_q, val_q};
					end else if (have_dst) begin
						status_next = STATUS_OK;
						wr_en = 1'b1;
						wr_addr = dst;
						wr_data = {SLOT_USED, key_q, val_q};
						cnt_next = cnt_q + CNT_W'(1);
					end else begin
						status_next = STATUS_FULL;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			tomb_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.operation == OP_UNUSED) ? ST_DONE : ST_HASH;
					end
				end
				ST_HASH: begin
					tomb_seen_q <= 1'b0;
					if (hash_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if (finish) begin
						cnt_q <= cnt_next;
						state_q <= ST_DONE;
					end else if (is_tomb && !tomb_seen_q) begin
						tomb_seen_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cnt_wide = WIDE_W'(cnt_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= req.operation;
				key_q <= req.key;
				val_q <= req.value;
				res_status_q <= STATUS_NOT_FOUND;
				res_val_q <= '0;
			end
			ST_HASH: begin
				idx_q <= hash_start;
				start_q <= hash_start;
				step_q <= hash_step;
			end
			ST_CHK: begin
				if (finish) begin
					res_status_q <= status_next;
					res_val_q <= val_next;
				end else begin
					idx_q <= idx_next;
					if (is_tomb && !tomb_seen_q) begin
						tomb_q <= idx_q;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_status_q <= res_status_q;
					out_val_q <= res_val_q;
					out_live_q <= cnt_wide[LIVE_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.result_value = out_val_q;
	assign rsp.live_count = out_live_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("live count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		(cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("live count moved by more than one");

	a_write_ends_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == ST_CHK) |=> (state_q == ST_DONE))
		else $error("slot write while probing continues");
`endif
endmodule
